// ===== design/first_fit_block_allocator_macros.svh =====
// Assertion macros for the first-fit block allocator.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define FBA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define FBA_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`else
`define FBA_ASSERT(lbl, prop)
`define FBA_ASSERT_MSG(lbl, prop, msg)
`endif
`endif

// ===== design/fba_pkg.sv =====
package fba_pkg;

  localparam int unsigned TotalKb    = 512;
  localparam int unsigned BlockSlots = 512;
  localparam int unsigned IdxW       = 9;
  localparam int unsigned CntW       = 10;
  localparam int unsigned StartW     = 9;
  localparam int unsigned SizeW      = 10;
  localparam int unsigned OwnerW     = 7;

  localparam logic FuncAlloc = 1'b0;
  localparam logic FuncFree  = 1'b1;

  localparam logic StatusDone = 1'b0;
  localparam logic StatusFail = 1'b1;

  typedef struct packed {
    logic [StartW-1:0] start;
    logic [SizeW-1:0]  size;
    logic              free;
    logic [OwnerW-1:0] owner;
  } entry_t;

  typedef struct packed {
    logic [SizeW-1:0] a;
    logic [SizeW-1:0] b;
    logic             sub;
  } alu_req_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_A_SCAN,
    ST_A_SHIFT,
    ST_A_SPLIT_HI,
    ST_A_SPLIT_LO,
    ST_A_SPLIT_WR,
    ST_F_SCAN,
    ST_F_FLUSH,
    ST_DONE
  } state_e;

endpackage

// ===== design/fba_table.sv =====
module fba_table
  import fba_pkg::*;
(
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  entry_t          wdata_i,
  input  logic [IdxW-1:0] raddr_i,
  output entry_t          rdata_o
);

  entry_t mem [BlockSlots];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/fba_alu.sv =====
module fba_alu
  import fba_pkg::*;
(
  input  alu_req_t       req_i,
  output logic [SizeW:0] res_o
);

  always_comb begin
    if (req_i.sub) begin
      res_o = {1'b0, req_i.a} - {1'b0, req_i.b};
    end else begin
      res_o = {1'b0, req_i.a} + {1'b0, req_i.b};
    end
  end

endmodule

// ===== design/first_fit_block_allocator.sv =====
// First-fit allocator over a 512 KB space held as an ordered table of up to 512
// blocks in a single-port-write, single-port-read RAM. After reset the block
// writes the initial free block and raises in_ready_o in the cycle after.
// One request is handled at a time; every table entry is first read from the
// RAM and then evaluated in the shared adder/comparator. The result sits in an
// output register, so it may wait for out_ready_i while the block returns to
// idle.
`include "first_fit_block_allocator_macros.svh"
module first_fit_block_allocator
  import fba_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              func_i,
  input  logic [OwnerW-1:0] owner_id_i,
  input  logic [SizeW-1:0]  size_kb_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              status_o,
  output logic [StartW-1:0] start_address_o
);

  state_e state_q, state_d;
  logic ph_q, ph_d;
  logic [CntW-1:0] ptr_q, ptr_d, count_q, count_d;
  logic [IdxW-1:0] hit_q, hit_d, w_q, w_d;
  entry_t acc_q, acc_d, blk_q, blk_d;
  logic acc_vld_q, acc_vld_d;
  logic [StartW-1:0] rem_start_q, rem_start_d;
  logic [OwnerW-1:0] owner_q, owner_d;
  logic [SizeW-1:0] size_q, size_d;
  logic res_status_q, res_status_d;
  logic [StartW-1:0] res_addr_q, res_addr_d;
  logic out_valid_q, out_valid_d, status_q, status_d;
  logic [StartW-1:0] addr_q, addr_d;

  logic mem_we;
  logic [IdxW-1:0] mem_waddr, mem_raddr;
  entry_t mem_wdata, rdata, ent;
  alu_req_t alu_req;
  logic [SizeW:0] alu_res;
  logic [CntW-1:0] ptr_inc;
  logic last;

  fba_table u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (rdata)
  );

  fba_alu u_alu (
    .req_i (alu_req),
    .res_o (alu_res)
  );

  assign ptr_inc = ptr_q + CntW'(1);
  assign last    = (ptr_inc == count_q);

  always_comb begin
    ent = rdata;
    if (!rdata.free && rdata.owner == owner_q) begin
      ent.free  = 1'b1;
      ent.owner = '0;
    end
  end

  always_comb begin
    state_d      = state_q;
    ph_d         = ph_q;
    ptr_d        = ptr_q;
    count_d      = count_q;
    hit_d        = hit_q;
    w_d          = w_q;
    acc_d        = acc_q;
    acc_vld_d    = acc_vld_q;
    blk_d        = blk_q;
    rem_start_d  = rem_start_q;
    owner_d      = owner_q;
    size_d       = size_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    status_d     = status_q;
    addr_d       = addr_q;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    mem_raddr    = ptr_q[IdxW-1:0];
    alu_req      = '{a: rdata.size, b: size_q, sub: 1'b1};
    in_ready_o   = 1'b0;

    unique case (state_q)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = '{start: '0, size: SizeW'(TotalKb), free: 1'b1, owner: '0};
        count_d   = CntW'(1);
        state_d   = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        ptr_d        = '0;
        ph_d         = 1'b0;
        w_d          = '0;
        acc_vld_d    = 1'b0;
        res_status_d = StatusDone;
        res_addr_d   = '0;
        if (in_valid_i) begin
          owner_d = owner_id_i;
          size_d  = size_kb_i;
          if (func_i == FuncFree) begin
            state_d = ST_F_SCAN;
          end else if (size_kb_i == '0) begin
            res_status_d = StatusFail;
            state_d      = ST_DONE;
          end else begin
            state_d = ST_A_SCAN;
          end
        end
      end
      ST_A_SCAN: begin
        ph_d = !ph_q;
        if (ph_q) begin
          if (rdata.free && !alu_res[SizeW]) begin
            hit_d = ptr_q[IdxW-1:0];
            blk_d = rdata;
            if (alu_res == '0) begin
              mem_we     = 1'b1;
              mem_waddr  = ptr_q[IdxW-1:0];
              mem_wdata  = '{start: rdata.start, size: rdata.size, free: 1'b0,
                             owner: owner_q};
              res_addr_d = rdata.start;
              state_d    = ST_DONE;
            end else if (count_q == CntW'(BlockSlots)) begin
              res_status_d = StatusFail;
              state_d      = ST_DONE;
            end else begin
              ptr_d   = count_q - CntW'(1);
              state_d = ST_A_SHIFT;
            end
          end else if (last) begin
            res_status_d = StatusFail;
            state_d      = ST_DONE;
          end else begin
            ptr_d = ptr_inc;
          end
        end
      end
      ST_A_SHIFT: begin
        if (!ph_q) begin
          if (ptr_q[IdxW-1:0] == hit_q) begin
            state_d = ST_A_SPLIT_HI;
          end else begin
            ph_d = 1'b1;
          end
        end else begin
          mem_we    = 1'b1;
          mem_waddr = ptr_inc[IdxW-1:0];
          mem_wdata = rdata;
          ptr_d     = ptr_q - CntW'(1);
          ph_d      = 1'b0;
        end
      end
      ST_A_SPLIT_HI: begin
        alu_req     = '{a: SizeW'(blk_q.start), b: size_q, sub: 1'b0};
        rem_start_d = alu_res[StartW-1:0];
        state_d     = ST_A_SPLIT_LO;
      end
      ST_A_SPLIT_LO: begin
        alu_req   = '{a: blk_q.size, b: size_q, sub: 1'b1};
        mem_we    = 1'b1;
        mem_waddr = hit_q + IdxW'(1);
        mem_wdata = '{start: rem_start_q, size: alu_res[SizeW-1:0], free: 1'b1,
                      owner: '0};
        state_d   = ST_A_SPLIT_WR;
      end
      ST_A_SPLIT_WR: begin
        mem_we     = 1'b1;
        mem_waddr  = hit_q;
        mem_wdata  = '{start: blk_q.start, size: size_q, free: 1'b0, owner: owner_q};
        count_d    = count_q + CntW'(1);
        res_addr_d = blk_q.start;
        state_d    = ST_DONE;
      end
      ST_F_SCAN: begin
        ph_d    = !ph_q;
        alu_req = '{a: acc_q.size, b: ent.size, sub: 1'b0};
        if (ph_q) begin
          if (acc_vld_q && acc_q.free && ent.free) begin
            acc_d.size = alu_res[SizeW-1:0];
          end else begin
            if (acc_vld_q) begin
              mem_we    = 1'b1;
              mem_waddr = w_q;
              mem_wdata = acc_q;
              w_d       = w_q + IdxW'(1);
            end
            acc_d     = ent;
            acc_vld_d = 1'b1;
          end
          if (last) begin
            state_d = ST_F_FLUSH;
          end else begin
            ptr_d = ptr_inc;
          end
        end
      end
      ST_F_FLUSH: begin
        mem_we    = 1'b1;
        mem_waddr = w_q;
        mem_wdata = acc_q;
        count_d   = CntW'(w_q) + CntW'(1);
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          status_d    = res_status_q;
          addr_d      = res_addr_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      ph_q        <= 1'b0;
      count_q     <= '0;
      acc_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ph_q        <= ph_d;
      count_q     <= count_d;
      acc_vld_q   <= acc_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q        <= ptr_d;
    hit_q        <= hit_d;
    w_q          <= w_d;
    acc_q        <= acc_d;
    blk_q        <= blk_d;
    rem_start_q  <= rem_start_d;
    owner_q      <= owner_d;
    size_q       <= size_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    status_q     <= status_d;
    addr_q       <= addr_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign start_address_o = addr_q;

  `FBA_ASSERT(a_count_valid, state_q == ST_INIT || (count_q != '0 && count_q <= CntW'(BlockSlots)))
  `FBA_ASSERT_MSG(a_busy_after_transfer, in_valid_i && in_ready_o |=> state_q != ST_IDLE, "request not taken")
  `FBA_ASSERT_MSG(a_compact_order, state_q == ST_F_SCAN |-> CntW'(w_q) <= ptr_q, "write passed read")

endmodule

// ===== test/first_fit_block_allocator_test.sv =====
module first_fit_block_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fba_pkg::*;

  typedef struct {
    logic              func;
    logic [OwnerW-1:0] owner;
    logic [SizeW-1:0]  size;
    bit                drain;
  } req_t;

  typedef struct {
    logic              status;
    logic [StartW-1:0] addr;
  } rsp_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic              func_i = FuncAlloc;
  logic [OwnerW-1:0] owner_id_i = '0;
  logic [SizeW-1:0]  size_kb_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic              status_o;
  logic [StartW-1:0] start_address_o;

  req_t pending_reqs[$];
  rsp_t expected_results[$];
  int   n_sent = 0;
  int   n_checked = 0;
  int   n_errors = 0;
  int   n_allocs = 0;
  int   n_frees = 0;
  int   n_fails = 0;
  int   n_total = 0;
  int   hold_cnt = 0;
  bit   hold_done = 1'b0;

  int unsigned blk_start[BlockSlots];
  int unsigned blk_size[BlockSlots];
  bit          blk_free[BlockSlots];
  int unsigned blk_owner[BlockSlots];
  int unsigned blk_count;

  first_fit_block_allocator u_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .func_i,
    .owner_id_i,
    .size_kb_i,
    .out_valid_o,
    .out_ready_i,
    .status_o,
    .start_address_o
  );

  always #1 clk_i = ~clk_i;

  function automatic void table_reset();
    blk_start[0] = 0;
    blk_size[0]  = TotalKb;
    blk_free[0]  = 1'b1;
    blk_owner[0] = 0;
    blk_count    = 1;
  endfunction

  function automatic void drop_block(int unsigned k);
    for (int unsigned j = k; j + 1 < blk_count; j++) begin
      blk_start[j] = blk_start[j+1];
      blk_size[j]  = blk_size[j+1];
      blk_free[j]  = blk_free[j+1];
      blk_owner[j] = blk_owner[j+1];
    end
    blk_count--;
  endfunction

  function automatic rsp_t alloc_first_fit(int unsigned owner, int unsigned size);
    rsp_t r;
    r.status = StatusFail;
    r.addr   = '0;
    if (size == 0) return r;
    for (int unsigned i = 0; i < blk_count; i++) begin
      if (blk_free[i] && blk_size[i] >= size) begin
        if (blk_size[i] > size) begin
          if (blk_count >= BlockSlots) return r;
          for (int unsigned j = blk_count; j > i + 1; j--) begin
            blk_start[j] = blk_start[j-1];
            blk_size[j]  = blk_size[j-1];
            blk_free[j]  = blk_free[j-1];
            blk_owner[j] = blk_owner[j-1];
          end
          blk_start[i+1] = blk_start[i] + size;
          blk_size[i+1]  = blk_size[i] - size;
          blk_free[i+1]  = 1'b1;
          blk_owner[i+1] = 0;
          blk_count++;
          blk_size[i] = size;
        end
        blk_free[i]  = 1'b0;
        blk_owner[i] = owner;
        r.status = StatusDone;
        r.addr   = blk_start[i][StartW-1:0];
        return r;
      end
    end
    return r;
  endfunction

  function automatic void release_owner(int unsigned owner);
    int unsigned i;
    i = 0;
    while (i < blk_count) begin
      if (!blk_free[i] && blk_owner[i] == owner) begin
        blk_free[i]  = 1'b1;
        blk_owner[i] = 0;
        if (i > 0 && blk_free[i-1]) begin
          blk_size[i-1] += blk_size[i];
          drop_block(i);
          i--;
        end
        if (i + 1 < blk_count && blk_free[i+1]) begin
          blk_size[i] += blk_size[i+1];
          drop_block(i + 1);
        end
      end
      i++;
    end
  endfunction

  function automatic void predict_request(req_t q);
    rsp_t r;
    if (q.func == FuncAlloc) begin
      r = alloc_first_fit(32'(q.owner), 32'(q.size));
      n_allocs++;
      if (r.status == StatusFail) n_fails++;
    end else begin
      release_owner(32'(q.owner));
      r.status = StatusDone;
      r.addr   = '0;
      n_frees++;
    end
    expected_results.push_back(r);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH result %0d: %s got %0d expected %0d", n_checked, what, got, want);
    n_errors++;
  endtask

  function automatic int send_idle_pct();
    if (n_sent < n_total / 3) return 22;
    if (n_sent < 2 * n_total / 3) return 75;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (n_sent < n_total / 3) return 75;
    if (n_sent < 2 * n_total / 3) return 22;
    return 0;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    bit fire;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      fire = in_valid_i && in_ready_o;
      if (fire) begin
        predict_request('{func_i, owner_id_i, size_kb_i, 1'b0});
        n_sent++;
      end
      if (!in_valid_i || fire) begin
        if (pending_reqs.size() != 0 &&
            !(pending_reqs[0].drain && expected_results.size() != 0) &&
            $urandom_range(99) >= send_idle_pct()) begin
          in_valid_i <= 1'b1;
          func_i     <= pending_reqs[0].func;
          owner_id_i <= pending_reqs[0].owner;
          size_kb_i  <= pending_reqs[0].size;
          void'(pending_reqs.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t e;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected transfer, address", int'(start_address_o), 0);
        end else begin
          e = expected_results.pop_front();
          if (status_o !== e.status)
            report_mismatch("status", int'(status_o), int'(e.status));
          if (start_address_o !== e.addr)
            report_mismatch("start_address", int'(start_address_o), int'(e.addr));
          n_checked++;
        end
      end
      if (!hold_done && n_sent >= 120) begin
        hold_done   <= 1'b1;
        hold_cnt    <= 400;
        out_ready_i <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt    <= hold_cnt - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct());
      end
    end
  end

  function automatic req_t mk(logic f, int owner, int size, bit drain = 1'b0);
    req_t q;
    q.func  = f;
    q.owner = owner[OwnerW-1:0];
    q.size  = size[SizeW-1:0];
    q.drain = drain;
    return q;
  endfunction

  initial begin
    req_t q;
    int   roll;
    table_reset();
    pending_reqs.push_back(mk(FuncAlloc, 0, 512));
    pending_reqs.push_back(mk(FuncAlloc, 3, 1));
    pending_reqs.push_back(mk(FuncFree, 5, 0));
    pending_reqs.push_back(mk(FuncFree, 0, 0));
    pending_reqs.push_back(mk(FuncAlloc, 4, 0));
    pending_reqs.push_back(mk(FuncAlloc, 4, 1023));
    pending_reqs.push_back(mk(FuncAlloc, 4, 513));
    pending_reqs.push_back(mk(FuncAlloc, 127, 1));
    pending_reqs.push_back(mk(FuncAlloc, 1, 100));
    pending_reqs.push_back(mk(FuncAlloc, 127, 3));
    pending_reqs.push_back(mk(FuncFree, 127, 0));
    pending_reqs.push_back(mk(FuncAlloc, 2, 2));
    pending_reqs.push_back(mk(FuncAlloc, 6, 512));
    pending_reqs.push_back(mk(FuncFree, 1, 0, 1'b1));
    pending_reqs.push_back(mk(FuncFree, 2, 0));
    pending_reqs.push_back(mk(FuncAlloc, 8, 768));
    pending_reqs.push_back(mk(FuncAlloc, 64, 256));
    pending_reqs.push_back(mk(FuncAlloc, 63, 256));
    pending_reqs.push_back(mk(FuncAlloc, 9, 1));
    pending_reqs.push_back(mk(FuncFree, 64, 0));
    pending_reqs.push_back(mk(FuncFree, 63, 0));
    for (int k = 0; k < 580; k++) begin
      roll = $urandom_range(99);
      if (roll < 25) begin
        q = mk(FuncFree, ($urandom_range(99) < 80) ? $urandom_range(7) : $urandom_range(127), 0);
      end else begin
        q = mk(FuncAlloc, ($urandom_range(99) < 80) ? $urandom_range(7) : $urandom_range(127),
               ($urandom_range(99) < 90) ? $urandom_range(24, 1) : $urandom_range(1023));
        q.size = ($urandom_range(99) < 5) ? SizeW'($urandom_range(1023)) : q.size;
      end
      q.drain = (k == 300);
      pending_reqs.push_back(q);
    end
    n_total = pending_reqs.size();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_reqs.size() == 0 && !in_valid_i);
    wait (expected_results.size() == 0);
    repeat (2100) @(posedge clk_i);
    $display("Covered %0d requests: %0d allocates (%0d refused) and %0d frees, %0d results checked",
             n_sent, n_allocs, n_fails, n_frees, n_checked);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout with %0d results outstanding", expected_results.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
